### rtl/core/olse_pkg.sv
// Shared types, constants and the exponent coefficient table for the
// streaming log-sum-exp accumulator. No dependencies.
package olse_pkg;

  localparam int COUNT_BITS = 20;
  localparam int FRAC_BITS  = 24;
  localparam int LOG2_BITS  = 24;
  localparam int EXP_STEPS  = 21;

  localparam int SUM_W  = COUNT_BITS + FRAC_BITS;
  localparam int NORM_W = (SUM_W < 32) ? 32 : SUM_W;
  localparam int P_W    = $clog2(NORM_W);
  localparam int HI_W   = (SUM_W > 32) ? SUM_W - 32 : 1;
  localparam int E_W    = FRAC_BITS + 1;
  localparam int K_W    = $clog2(LOG2_BITS);
  localparam int MUL_W  = 33;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam int DATA_IN_W  = 32;
  localparam int DATA_OUT_W = 120;

  // Command codes carried on in_tuser.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECIDE, OP_EXP_INIT, OP_EXP_STEP, OP_EXP_DONE,
    OP_SCL_LO, OP_SCL_HI, OP_UPDATE, OP_LN_INIT, OP_LN_NORM, OP_LN_SQR,
    OP_LN_MUL, OP_LN_DONE, OP_FINAL
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_EXP_INIT, ST_EXP_RUN, ST_EXP_DONE, ST_SCL_LO,
    ST_SCL_HI, ST_UPDATE, ST_LN_INIT, ST_LN_NORM, ST_LN_SQR, ST_LN_MUL,
    ST_LN_DONE, ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic go_add;
    logic grow;
    logic sel;
    logic exp_last;
    logic norm_done;
    logic sqr_last;
    logic ln_skip;
    logic out_free;
  } dp_status_t;

  // round(2^32 * exp(-2^(k-16))) for each bit k of a Q16.16 argument.
  function automatic logic [31:0] exp_coef(input logic [K_W-1:0] k);
    logic [31:0] c;
    case (k)
      5'd0:    c = 32'd4294901760;
      5'd1:    c = 32'd4294836226;
      5'd2:    c = 32'd4294705160;
      5'd3:    c = 32'd4294443040;
      5'd4:    c = 32'd4293918848;
      5'd5:    c = 32'd4292870656;
      5'd6:    c = 32'd4290775039;
      5'd7:    c = 32'd4286586875;
      5'd8:    c = 32'd4278222805;
      5'd9:    c = 32'd4261543595;
      5'd10:   c = 32'd4228380000;
      5'd11:   c = 32'd4162825044;
      5'd12:   c = 32'd4034748382;
      5'd13:   c = 32'd3790295335;
      5'd14:   c = 32'd3344923893;
      5'd15:   c = 32'd2605029347;
      5'd16:   c = 32'd1580030169;
      5'd17:   c = 32'd581260615;
      5'd18:   c = 32'd78665070;
      5'd19:   c = 32'd1440801;
      5'd20:   c = 32'd483;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/olse_ctrl.sv
// Sequencer for the log-sum-exp accumulator: walks each transaction through
// exponent, rescale, update and log phases it needs. Depends on olse_pkg.
module olse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  olse_pkg::dp_status_t status,
  output olse_pkg::dp_op_t     op
);
  import olse_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = status.go_add ? ST_EXP_INIT : ST_LN_INIT;
      ST_EXP_INIT: state_nxt = ST_EXP_RUN;
      ST_EXP_RUN:  if (status.exp_last) state_nxt = ST_EXP_DONE;
      ST_EXP_DONE: begin
        if (!status.sel) state_nxt = ST_EXP_INIT;
        else state_nxt = status.grow ? ST_SCL_LO : ST_UPDATE;
      end
      ST_SCL_LO:   state_nxt = ST_SCL_HI;
      ST_SCL_HI:   state_nxt = status.sel ? ST_UPDATE : ST_SCL_LO;
      ST_UPDATE:   state_nxt = ST_LN_INIT;
      ST_LN_INIT:  state_nxt = status.ln_skip ? ST_LN_DONE : ST_LN_NORM;
      ST_LN_NORM:  if (status.norm_done) state_nxt = ST_LN_SQR;
      ST_LN_SQR:   if (status.sqr_last) state_nxt = ST_LN_MUL;
      ST_LN_MUL:   state_nxt = ST_LN_DONE;
      ST_LN_DONE:  state_nxt = status.sel ? ST_OUT : ST_LN_INIT;
      ST_OUT:      if (status.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) op = OP_LOAD;
      end
      ST_DECIDE:   op = OP_DECIDE;
      ST_EXP_INIT: op = OP_EXP_INIT;
      ST_EXP_RUN:  op = OP_EXP_STEP;
      ST_EXP_DONE: op = OP_EXP_DONE;
      ST_SCL_LO:   op = OP_SCL_LO;
      ST_SCL_HI:   op = OP_SCL_HI;
      ST_UPDATE:   op = OP_UPDATE;
      ST_LN_INIT:  op = OP_LN_INIT;
      ST_LN_NORM:  op = OP_LN_NORM;
      ST_LN_SQR:   op = OP_LN_SQR;
      ST_LN_MUL:   op = OP_LN_MUL;
      ST_LN_DONE:  op = OP_LN_DONE;
      ST_OUT:      if (status.out_free) op = OP_FINAL;
      default:     op = OP_NONE;
    endcase
  end

endmodule

### rtl/core/olse_dp.sv
// Datapath of the log-sum-exp accumulator: accumulator state, one shared
// 33x33 multiplier, exponent, scaling and logarithm registers, result register.
// Depends on olse_pkg; driven by olse_ctrl.
module olse_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  olse_pkg::dp_op_t                   op,
  input  logic                               in_cmd,
  input  logic [31:0]                        in_value,
  output olse_pkg::dp_status_t               status,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [olse_pkg::DATA_OUT_W-1:0]    out_tdata
);
  import olse_pkg::*;

  localparam int EXT_W = 32 + HI_W;
  localparam logic [SUM_W-1:0] ONE_FIX = SUM_W'(1) << FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Accumulator state.
  logic [COUNT_BITS-1:0] cnt_r;
  logic signed [31:0]    max_r;
  logic [SUM_W-1:0]      sum_r, sq_r;

  // Per-transaction work registers.
  logic                  cmd_r, grow_r, sel_r, sat_r, ezero_r, neg_r;
  logic signed [31:0]    x_r;
  logic [31:0]           t_r;
  logic [32:0]           ts_r;
  logic [32:0]           acc_r;
  logic [K_W-1:0]        k_r;
  logic [E_W-1:0]        e_s_r, e_q_r;
  logic [32:0]           part_r;
  logic [NORM_W-1:0]     n_r;
  logic [P_W-1:0]        p_r;
  logic [31:0]           m_r;
  logic [LOG2_BITS-1:0]  frac_r;
  logic [63:0]           lnprod_r;
  logic signed [31:0]    ln_s_r, ln_q_r;

  logic                  out_valid_r;
  logic [DATA_OUT_W-1:0] out_data_r;

  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    prod;

  logic [SUM_W-1:0]      s_sel;
  logic [EXT_W-1:0]      s_ext;
  logic [E_W-1:0]        e_sel;
  logic [SUM_W-1:0]      scaled;
  logic [32:0]           m2;
  logic signed [P_W+1:0] pd;
  logic signed [P_W+LOG2_BITS+1:0] l_val;
  logic [31:0]           l_mag;
  logic [63:0]           rnd;
  logic signed [31:0]    ln_val;
  logic signed [33:0]    ls_sum;
  logic signed [34:0]    lq_sum;
  logic [31:0]           ls_out, lq_out;
  logic                  empty_now;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -35'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  assign s_sel = sel_r ? sq_r : sum_r;
  assign s_ext = EXT_W'(s_sel);
  assign e_sel = sel_r ? e_q_r : e_s_r;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_EXP_STEP: begin
        mul_a = acc_r;
        mul_b = {1'b0, exp_coef(k_r)};
      end
      OP_SCL_LO: begin
        mul_a = MUL_W'(s_ext[31:0]);
        mul_b = MUL_W'(e_sel);
      end
      OP_SCL_HI: begin
        mul_a = MUL_W'(s_ext[EXT_W-1:32]);
        mul_b = MUL_W'(e_sel);
      end
      OP_LN_SQR: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      OP_LN_MUL: begin
        mul_a = {1'b0, l_mag};
        mul_b = {1'b0, LN2_Q32};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign scaled = SUM_W'((prod << (32 - FRAC_BITS)) + 66'(part_r));
  assign m2     = prod[63:31];

  // log2 in Q.LOG2_BITS: the exponent part sits above the fraction bits.
  assign pd     = $signed({2'b00, p_r}) - (P_W + 2)'(FRAC_BITS);
  assign l_val  = $signed({pd, frac_r});
  assign l_mag  = l_val[P_W+LOG2_BITS+1] ? 32'(-l_val) : 32'(l_val);
  assign rnd    = lnprod_r + (64'd1 << 39);
  assign ln_val = neg_r ? -$signed(32'(rnd[63:40])) : $signed(32'(rnd[63:40]));

  assign empty_now = (cnt_r == '0);
  assign ls_sum = 34'(max_r) + 34'(ln_s_r);
  assign lq_sum = (35'(max_r) <<< 1) + 35'(ln_q_r);
  assign ls_out = empty_now ? 32'h8000_0000 : sat32(35'(ls_sum));
  assign lq_out = empty_now ? 32'h8000_0000 : sat32(lq_sum);

  always_comb begin
    status.go_add    = (cmd_r == CMD_ADD) && (cnt_r != '0) && (cnt_r != CNT_MAX);
    status.grow      = grow_r;
    status.sel       = sel_r;
    status.exp_last  = (k_r == K_W'(EXP_STEPS - 1));
    status.norm_done = n_r[NORM_W-1];
    status.sqr_last  = (k_r == K_W'(LOG2_BITS - 1));
    status.ln_skip   = empty_now || (s_sel == '0);
    status.out_free  = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_FINAL) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (op)
        OP_LOAD: begin
          cmd_r <= in_cmd;
          x_r   <= $signed(in_value);
        end
        OP_DECIDE: begin
          sel_r  <= 1'b0;
          sat_r  <= (cmd_r == CMD_ADD) && (cnt_r == CNT_MAX);
          grow_r <= (x_r > max_r);
          t_r    <= (x_r > max_r) ? 32'(x_r - max_r) : 32'(max_r - x_r);
          if (cmd_r == CMD_CLEAR) begin
            cnt_r <= '0;
            max_r <= '0;
            sum_r <= '0;
            sq_r  <= '0;
          end else if (cnt_r == '0) begin
            cnt_r <= COUNT_BITS'(1);
            max_r <= x_r;
            sum_r <= ONE_FIX;
            sq_r  <= ONE_FIX;
          end
        end
        OP_EXP_INIT: begin
          acc_r   <= 33'd1 << 32;
          k_r     <= '0;
          ts_r    <= sel_r ? {t_r, 1'b0} : {1'b0, t_r};
          ezero_r <= sel_r ? (t_r[31:20] != '0) : (t_r[31:21] != '0);
        end
        OP_EXP_STEP: begin
          if (ts_r[0]) acc_r <= prod[64:32];
          ts_r <= ts_r >> 1;
          k_r  <= k_r + K_W'(1);
        end
        OP_EXP_DONE: begin
          if (sel_r) e_q_r <= ezero_r ? '0 : acc_r[32 -: E_W];
          else e_s_r <= ezero_r ? '0 : acc_r[32 -: E_W];
          sel_r <= !sel_r;
        end
        OP_SCL_LO: begin
          part_r <= prod[FRAC_BITS +: 33];
        end
        OP_SCL_HI: begin
          if (sel_r) sq_r <= scaled;
          else sum_r <= scaled;
          sel_r <= !sel_r;
        end
        OP_UPDATE: begin
          // A new maximum contributes exactly 1.0 after the rescale.
          sum_r <= sum_r + (grow_r ? ONE_FIX : SUM_W'(e_s_r));
          sq_r  <= sq_r + (grow_r ? ONE_FIX : SUM_W'(e_q_r));
          if (grow_r) max_r <= x_r;
          cnt_r <= cnt_r + COUNT_BITS'(1);
        end
        OP_LN_INIT: begin
          n_r      <= NORM_W'(s_sel);
          p_r      <= P_W'(NORM_W - 1);
          frac_r   <= '0;
          lnprod_r <= '0;
          neg_r    <= 1'b0;
        end
        OP_LN_NORM: begin
          if (n_r[NORM_W-1]) begin
            m_r <= n_r[NORM_W-1 -: 32];
            k_r <= '0;
          end else begin
            n_r <= n_r << 1;
            p_r <= p_r - P_W'(1);
          end
        end
        OP_LN_SQR: begin
          frac_r <= {frac_r[LOG2_BITS-2:0], m2[32]};
          m_r    <= m2[32] ? m2[32:1] : m2[31:0];
          k_r    <= k_r + K_W'(1);
        end
        OP_LN_MUL: begin
          lnprod_r <= prod[63:0];
          neg_r    <= l_val[P_W+LOG2_BITS+1];
        end
        OP_LN_DONE: begin
          if (sel_r) ln_q_r <= ln_val;
          else ln_s_r <= ln_val;
          sel_r <= !sel_r;
        end
        OP_FINAL: begin
          out_data_r <= {2'b00, sat_r, empty_now, cnt_r, max_r, lq_out, ls_out};
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_update_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_UPDATE |=> cnt_r != '0)
    else $error("count is zero after an add");

  a_mantissa_norm: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_LN_SQR |-> m_r[31])
    else $error("log mantissa not normalized");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_FINAL && empty_now |=> out_data_r[31:0] == 32'h8000_0000)
    else $error("empty accumulator reported a finite log sum");

  a_sel_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_FINAL |-> !sel_r)
    else $error("phase select left set at result time");

endmodule

### rtl/core/online_log_sum_exp_accumulator_unit.sv
// Top level of the streaming log-sum-exp accumulator: controller plus datapath.
// A clear, a first add and an ignored add go straight to the logarithms; other adds first run
// two exponent passes, rescale both sums on a new maximum and update them. Each logarithm
// shifts the sum once per leading zero (at most 19) before its squaring steps. One transaction
// at a time: the next is accepted once the controller is back in idle, after the result is
// loaded into the output register. Reset (synchronous, rst_n low) empties the accumulator.
module online_log_sum_exp_accumulator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [olse_pkg::DATA_IN_W-1:0]  in_tdata,   // x_log
  input  logic                            in_tuser,   // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // log_sum, log_sum_squares, max_log, count, empty_res, saturated, zero pad
  output logic [olse_pkg::DATA_OUT_W-1:0] out_tdata
);
  import olse_pkg::*;

  dp_status_t status;
  dp_op_t     op;

  olse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .op        (op)
  );

  olse_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .in_cmd     (in_tuser),
    .in_value   (in_tdata),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sim/olse_result_checker.sv
// Watches both streams of the log-sum-exp accumulator, predicts every result
// with a fixed-point model of its own, and compares. Depends on olse_pkg.
`timescale 1ns / 100ps
module olse_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [olse_pkg::DATA_IN_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [olse_pkg::DATA_OUT_W-1:0] out_tdata,
  input  logic                            drain_done,
  output int                              fail_count,
  output int                              pending_results
);
  import olse_pkg::*;

  localparam logic [63:0] SUM_MASK   = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] COUNT_TOP  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] ONE_FIX    = 64'd1 << FRAC_BITS;

  // Highest field first, so log_sum lands in the lowest bits.
  typedef struct packed {
    logic        saturated;
    logic        empty_res;
    logic [19:0] count;
    logic [31:0] max_log;
    logic [31:0] log_sum_sq;
    logic [31:0] log_sum;
  } lse_result_t;

  lse_result_t    expected_results[$];
  logic [63:0]    acc_count;
  longint         acc_max;
  logic [63:0]    acc_sum;
  logic [63:0]    acc_sum_sq;

  logic [31:0] exp_weights [21] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
    32'd483};

  function automatic logic [63:0] exp_neg_fix(input logic [63:0] t);
    logic [63:0] a;
    a = 64'd1 << 32;
    if (t >= (64'd1 << 21)) return 64'd0;
    for (int j = 0; j < 21; j++)
      if (t[j]) a = (a * {32'd0, exp_weights[j]}) >> 32;
    return a >> (32 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] rescale(input logic [63:0] s, input logic [63:0] e);
    logic [63:0] hi, lo;
    hi = s >> 32;
    lo = s & 64'hFFFF_FFFF;
    return (((hi * e) << (32 - FRAC_BITS)) + ((lo * e) >> FRAC_BITS)) & SUM_MASK;
  endfunction

  function automatic longint ln_fix(input logic [63:0] s);
    int p;
    logic [63:0] m, frac, mag;
    longint l;
    frac = 0;
    if (s == 0) return 0;
    p = 63;
    while (!s[p]) p--;
    m = (p >= 31) ? (s >> (p - 31)) : (s << (31 - p));
    for (int i = 0; i < LOG2_BITS; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    l = longint'(p - FRAC_BITS) * (longint'(1) << LOG2_BITS) + longint'(frac);
    if (l >= 0) begin
      mag = (64'(l) * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
      return longint'(mag);
    end
    mag = (64'(-l) * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
    return -longint'(mag);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic lse_result_t accumulate(input logic cmd, input logic [31:0] raw);
    lse_result_t r;
    longint x, ls, lq;
    logic [63:0] t;
    x = longint'($signed(raw));
    r.saturated = 1'b0;
    if (cmd == CMD_CLEAR) begin
      acc_count = 0; acc_max = 0; acc_sum = 0; acc_sum_sq = 0;
    end else if (acc_count == COUNT_TOP) begin
      r.saturated = 1'b1;
    end else begin
      if (acc_count == 0) begin
        acc_max = x; acc_sum = ONE_FIX; acc_sum_sq = ONE_FIX;
      end else begin
        if (x > acc_max) begin
          t = 64'(x - acc_max);
          acc_sum = rescale(acc_sum, exp_neg_fix(t));
          acc_sum_sq = rescale(acc_sum_sq, exp_neg_fix(2 * t));
          acc_max = x;
        end
        t = 64'(acc_max - x);
        acc_sum = (acc_sum + exp_neg_fix(t)) & SUM_MASK;
        acc_sum_sq = (acc_sum_sq + exp_neg_fix(2 * t)) & SUM_MASK;
      end
      acc_count = (acc_count + 1) & COUNT_TOP;
    end
    if (acc_count == 0) begin
      ls = -64'sd2147483648;
      lq = -64'sd2147483648;
    end else begin
      ls = clip32(acc_max + ln_fix(acc_sum));
      lq = clip32(2 * acc_max + ln_fix(acc_sum_sq));
    end
    r.log_sum = ls[31:0];
    r.log_sum_sq = lq[31:0];
    r.max_log = acc_max[31:0];
    r.count = acc_count[19:0];
    r.empty_res = (acc_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    lse_result_t got, want;
    if (!rst_n) begin
      acc_count = 0; acc_max = 0; acc_sum = 0; acc_sum_sq = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(accumulate(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[117:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", got.log_sum, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.log_sum !== want.log_sum)
            report_mismatch("log_sum", got.log_sum, want.log_sum);
          if (got.log_sum_sq !== want.log_sum_sq)
            report_mismatch("log_sum_squares", got.log_sum_sq, want.log_sum_sq);
          if (got.max_log !== want.max_log)
            report_mismatch("max_log", got.max_log, want.max_log);
          if (got.count !== want.count)
            report_mismatch("count", 32'(got.count), 32'(want.count));
          if (got.empty_res !== want.empty_res)
            report_mismatch("empty_res", 32'(got.empty_res), 32'(want.empty_res));
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        end
      end
      // Results still owed once the stream has drained count as a failure.
      if (drain_done && expected_results.size() != 0) begin
        report_mismatch("missing results", 32'(expected_results.size()), 32'd0);
        expected_results.delete();
      end
    end
    pending_results = expected_results.size();
  end
endmodule

### sim/online_log_sum_exp_accumulator_unit_tb.sv
// Stimulus and verdict for the streaming log-sum-exp accumulator. Needs
// olse_pkg, the block itself and olse_result_checker.
`timescale 1ns / 100ps
module online_log_sum_exp_accumulator_unit_tb;
  import olse_pkg::*;

  localparam int   IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_OUT_W-1:0] out_tdata;
  logic drain_done = 1'b0;
  int   fail_count;
  int   pending_results;
  int   idle_cycles = 0;

  typedef struct { logic cmd; logic [31:0] val; } lse_item_t;
  lse_item_t stimulus_items[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  online_log_sum_exp_accumulator_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  olse_result_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .drain_done, .fail_count, .pending_results
  );

  // Receiver: fully open in one window out of three, else ready at random 65% of the time.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if ((($time / 4000) % 3) == 0) out_tready <= 1'b1;
    else out_tready <= (r < 65);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("online_log_sum_exp_accumulator_unit verification failed");
      $finish;
    end
  end

  task automatic add_item(input logic cmd, input logic [31:0] val);
    stimulus_items.push_back('{cmd, val});
  endtask

  function automatic logic [31:0] random_log(input logic [31:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return base + 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
    if (r < 7) return base + 32'($signed($urandom_range(0, 80 << 16)) - (40 << 16));
    if (r < 8) return base;
    return $urandom;
  endfunction

  initial begin
    int burst;
    logic [31:0] base;
    add_item(CMD_ADD, 32'h0000_0000);
    add_item(CMD_ADD, 32'h0000_0000);
    add_item(CMD_ADD, 32'h0001_0000);
    add_item(CMD_ADD, 32'hFFE0_0000);
    add_item(CMD_ADD, 32'h0021_0000);
    add_item(CMD_ADD, 32'h7FFF_FFFF);
    add_item(CMD_ADD, 32'h8000_0000);
    add_item(CMD_CLEAR, 32'hFFFF_FFFF);
    add_item(CMD_CLEAR, 32'h0000_0000);
    add_item(CMD_ADD, 32'h8000_0000);
    add_item(CMD_ADD, 32'h8000_0001);
    add_item(CMD_ADD, 32'h7FFF_FFFF);
    add_item(CMD_CLEAR, 32'h1234_5678);
    add_item(CMD_ADD, 32'h4000_0000);
    add_item(CMD_ADD, 32'h3FFF_FFFF);
    add_item(CMD_ADD, 32'h4000_0000);
    add_item(CMD_ADD, 32'h4000_8000);
    add_item(CMD_CLEAR, 32'h0);
    // Random runs of mostly adds, each around a new random base, split by clears.
    while (stimulus_items.size() < 1270) begin
      base = $urandom;
      if ($urandom_range(0, 3) == 0) base = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      burst = $urandom_range(1, 40);
      repeat (burst) add_item(($urandom_range(0, 30) == 0) ? CMD_CLEAR : CMD_ADD,
                              random_log(base));
      add_item(CMD_CLEAR, $urandom);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stimulus_items.size() != 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && stimulus_items.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= stimulus_items[0].cmd;
        in_tdata <= stimulus_items[0].val;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        void'(stimulus_items.pop_front());
        burst--;
      end
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    drain_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) begin
      $display("online_log_sum_exp_accumulator_unit verification clean");
    end else begin
      $display("online_log_sum_exp_accumulator_unit verification failed");
    end
    $finish;
  end
endmodule
